[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check prop at every clock edge outside reset
`define CST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// check prop at every clock edge, reset included
`define CST_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define CST_ASSERT(lbl, clk, rst_n, prop)
`define CST_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/cst_pkg.sv]
// ----------------------------------------------------------------------------
// cst_pkg
// shared types and codes of the chained scatter hash table
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int HOME_W      = 6;
    localparam int CNT_W       = 7;
    localparam int DEF_BUCKETS = 64;

    // operation codes
    localparam logic [1:0] FN_LOOKUP = 2'd0;
    localparam logic [1:0] FN_INSERT = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;
    localparam logic [1:0] FN_POP    = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  key;
        logic [HOME_W-1:0] home_bucket;
        logic [VAL_W-1:0]  value;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [VAL_W-1:0] value_out;
        logic [CNT_W-1:0] entry_count;
    } out_t;

endpackage

[sv/cst_ram.sv]
// ----------------------------------------------------------------------------
// cst_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/cst_ctrl.sv]
// ----------------------------------------------------------------------------
// cst_ctrl
// sequencer that walks bucket chains one link at a time through the two rams
// ----------------------------------------------------------------------------
module cst_ctrl #(
    parameter int BUCKETS = cst_pkg::DEF_BUCKETS,
    localparam int AW = $clog2(BUCKETS),
    localparam int NW = $clog2(BUCKETS + 1),
    localparam int CW = $clog2(BUCKETS + 1),
    localparam int BW = AW + NW,
    localparam int EW = cst_pkg::KEY_W + cst_pkg::VAL_W + AW
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cst_pkg::in_t   in_item,
    output logic           res_valid,
    input  logic           res_ready,
    output cst_pkg::out_t  res_item,
    output logic [CW-1:0]  count_out,
    output logic           b_we,
    output logic [AW-1:0]  b_waddr,
    output logic [BW-1:0]  b_wdata,
    output logic [AW-1:0]  b_raddr,
    input  logic [BW-1:0]  b_rdata,
    output logic           e_we,
    output logic [AW-1:0]  e_waddr,
    output logic [EW-1:0]  e_wdata,
    output logic [AW-1:0]  e_raddr,
    input  logic [EW-1:0]  e_rdata
);
    import cst_pkg::*;

    localparam logic [NW-1:0] END_N = NW'(BUCKETS);
    localparam logic [CW-1:0] FULL_C = CW'(BUCKETS);

    typedef enum logic [4:0] {
        S_IDLE, S_LAST_RD, S_LAST, S_MOD, S_FIND, S_FIND_B, S_FIND_E, S_MISS,
        S_FPS, S_H_RD, S_H, S_H_E, S_PW_RD, S_PW, S_MV1, S_SET_H, S_SET_F,
        S_RL_RD, S_RL, S_RW_RD, S_RW, S_MEND, S_MP, S_MN, S_DONE
    } state_t;

    state_t              state_reg;
    logic [1:0]          func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [HOME_W-1:0]   hin_reg;
    logic [AW-1:0]       cur_reg;
    logic [AW-1:0]       bkt_reg;
    logic [NW-1:0]       prev_reg;
    logic [NW-1:0]       nxt_reg;
    logic [AW-1:0]       ent_reg;
    logic [AW-1:0]       eh_reg;
    logic [NW-1:0]       nh_reg;
    logic                squat_reg;
    logic [CW-1:0]       count_reg;
    logic [AW-1:0]       fp_reg;
    logic [BUCKETS-1:0]  used_reg;
    logic [1:0]          status_reg;
    logic                found_reg;
    logic [VAL_W-1:0]    vout_reg;

    logic [AW-1:0]    home_a;
    logic [NW-1:0]    home_n;
    logic [CW-1:0]    last_c;
    logic [AW-1:0]    last_a;
    logic [AW-1:0]    b_ent;
    logic [NW-1:0]    b_nxt;
    logic [KEY_W-1:0] e_key;
    logic [VAL_W-1:0] e_val;
    logic [AW-1:0]    e_home;
    logic             hit;
    logic [AW-1:0]    nxt_a;
    logic [AW-1:0]    prev_a;

    // field views of the ram words and shared compare
    assign home_a = AW'(hin_reg);
    assign home_n = NW'(home_a);
    assign last_c = count_reg - CW'(1);
    assign last_a = last_c[AW-1:0];
    assign b_ent  = b_rdata[BW-1:NW];
    assign b_nxt  = b_rdata[NW-1:0];
    assign e_home = e_rdata[AW-1:0];
    assign e_val  = e_rdata[AW+VAL_W-1:AW];
    assign e_key  = e_rdata[EW-1:AW+VAL_W];
    assign hit    = (e_key == key_reg) && (e_home == home_a);
    assign nxt_a  = nxt_reg[AW-1:0];
    assign prev_a = prev_reg[AW-1:0];

    // ram read addresses
    always_comb begin
        b_raddr = cur_reg;
        e_raddr = last_a;
        case (state_reg)
            S_H_RD:  b_raddr = home_a;
            S_MEND:  b_raddr = (prev_reg < END_N) ? prev_a : nxt_a;
            S_FIND_B, S_H: e_raddr = b_ent;
            default: ;
        endcase
    end

    // ram writes
    always_comb begin
        b_we    = 1'b0;
        b_waddr = cur_reg;
        b_wdata = {b_ent, b_nxt};
        e_we    = 1'b0;
        e_waddr = ent_reg;
        e_wdata = {key_reg, val_reg, home_a};
        case (state_reg)
            S_FIND_E: e_we = hit && (func_reg == FN_INSERT);
            S_MISS: begin
                e_we    = (func_reg == FN_INSERT) && (count_reg < FULL_C);
                e_waddr = count_reg[AW-1:0];
            end
            S_RL: begin
                e_we    = 1'b1;
                e_wdata = e_rdata;
            end
            S_SET_H: begin
                b_we    = 1'b1;
                b_waddr = home_a;
                b_wdata = {ent_reg, END_N};
            end
            S_PW: begin
                b_we    = squat_reg ? (b_nxt == home_n) : (b_nxt >= END_N);
                b_wdata = {b_ent, NW'(fp_reg)};
            end
            S_MV1: begin
                b_we    = 1'b1;
                b_waddr = fp_reg;
                b_wdata = {eh_reg, nh_reg};
            end
            S_SET_F: begin
                b_we    = 1'b1;
                b_waddr = fp_reg;
                b_wdata = {ent_reg, END_N};
            end
            S_RW: begin
                b_we    = used_reg[cur_reg] && (b_ent == last_a);
                b_wdata = {ent_reg, b_nxt};
            end
            S_MP: begin
                b_we    = 1'b1;
                b_waddr = prev_a;
                b_wdata = {b_ent, nxt_reg};
            end
            S_MN: begin
                b_we    = 1'b1;
                b_waddr = bkt_reg;
                b_wdata = b_rdata;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            fp_reg    <= AW'(BUCKETS - 1);
            used_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        func_reg   <= in_item.func;
                        key_reg    <= in_item.key;
                        val_reg    <= in_item.value;
                        hin_reg    <= in_item.home_bucket;
                        status_reg <= ST_MISS;
                        found_reg  <= 1'b0;
                        vout_reg   <= '0;
                        prev_reg   <= END_N;
                        if (in_item.func != FN_POP) begin
                            state_reg <= S_MOD;
                        end else if (count_reg != '0) begin
                            state_reg <= S_LAST_RD;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_LAST_RD: state_reg <= S_LAST;
                S_LAST: begin
                    key_reg   <= e_key;
                    hin_reg   <= HOME_W'(e_home);
                    cur_reg   <= e_home;
                    func_reg  <= FN_REMOVE;
                    state_reg <= S_FIND;
                end
                // home reduced by repeated subtraction
                S_MOD: begin
                    if (int'(hin_reg) >= BUCKETS) begin
                        hin_reg <= hin_reg - HOME_W'(BUCKETS);
                    end else begin
                        cur_reg   <= home_a;
                        state_reg <= S_FIND;
                    end
                end
                // chain walk: used check, bucket word, entry word
                S_FIND: state_reg <= used_reg[cur_reg] ? S_FIND_B : S_MISS;
                S_FIND_B: begin
                    ent_reg   <= b_ent;
                    nxt_reg   <= b_nxt;
                    state_reg <= S_FIND_E;
                end
                S_FIND_E: begin
                    if (hit) begin
                        status_reg <= ST_DONE;
                        found_reg  <= 1'b1;
                        bkt_reg    <= cur_reg;
                        if (func_reg == FN_LOOKUP) begin
                            vout_reg  <= e_val;
                            state_reg <= S_DONE;
                        end else if (func_reg == FN_INSERT) begin
                            state_reg <= S_DONE;
                        end else if (ent_reg != last_a) begin
                            state_reg <= S_RL_RD;
                        end else begin
                            state_reg <= S_MEND;
                        end
                    end else if (nxt_reg >= END_N) begin
                        state_reg <= S_MISS;
                    end else begin
                        prev_reg  <= NW'(cur_reg);
                        cur_reg   <= nxt_a;
                        state_reg <= S_FIND;
                    end
                end
                // new key: append entry, then link its bucket
                S_MISS: begin
                    if (func_reg != FN_INSERT) begin
                        state_reg <= S_DONE;
                    end else if (count_reg >= FULL_C) begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_DONE;
                    end else begin
                        status_reg <= ST_DONE;
                        ent_reg    <= count_reg[AW-1:0];
                        count_reg  <= count_reg + CW'(1);
                        state_reg  <= used_reg[home_a] ? S_FPS : S_SET_H;
                    end
                end
                // free bucket search, one bucket per cycle
                S_FPS: begin
                    if (fp_reg != '0 && used_reg[fp_reg]) begin
                        fp_reg <= fp_reg - AW'(1);
                    end else if (used_reg[fp_reg]) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_H_RD;
                    end
                end
                S_H_RD: state_reg <= S_H;
                S_H: begin
                    eh_reg    <= b_ent;
                    nh_reg    <= b_nxt;
                    state_reg <= S_H_E;
                end
                S_H_E: begin
                    squat_reg <= (e_home != home_a);
                    cur_reg   <= e_home;
                    state_reg <= S_PW_RD;
                end
                S_PW_RD: state_reg <= S_PW;
                // squatter mode looks for the link into home, else the chain tail
                S_PW: begin
                    if (squat_reg && b_nxt == home_n) begin
                        state_reg <= S_MV1;
                    end else if (b_nxt >= END_N) begin
                        state_reg <= squat_reg ? S_DONE : S_SET_F;
                    end else begin
                        cur_reg   <= b_nxt[AW-1:0];
                        state_reg <= S_PW_RD;
                    end
                end
                S_MV1: begin
                    used_reg[fp_reg] <= 1'b1;
                    state_reg        <= S_SET_H;
                end
                S_SET_H: begin
                    used_reg[home_a] <= 1'b1;
                    state_reg        <= S_DONE;
                end
                S_SET_F: begin
                    used_reg[fp_reg] <= 1'b1;
                    state_reg        <= S_DONE;
                end
                // move last entry into the hole and relink its bucket
                S_RL_RD: state_reg <= S_RL;
                S_RL: begin
                    cur_reg   <= e_home;
                    state_reg <= S_RW_RD;
                end
                S_RW_RD: state_reg <= S_RW;
                S_RW: begin
                    if (!used_reg[cur_reg] || b_ent == last_a || b_nxt >= END_N) begin
                        state_reg <= S_MEND;
                    end else begin
                        cur_reg   <= b_nxt[AW-1:0];
                        state_reg <= S_RW_RD;
                    end
                end
                // unlink the removed bucket
                S_MEND: begin
                    count_reg <= last_c;
                    if (prev_reg < END_N) begin
                        state_reg <= S_MP;
                    end else if (nxt_reg < END_N) begin
                        state_reg <= S_MN;
                    end else begin
                        used_reg[bkt_reg] <= 1'b0;
                        if (bkt_reg > fp_reg) begin
                            fp_reg <= bkt_reg;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_MP: begin
                    used_reg[bkt_reg] <= 1'b0;
                    if (bkt_reg > fp_reg) begin
                        fp_reg <= bkt_reg;
                    end
                    state_reg <= S_DONE;
                end
                S_MN: begin
                    used_reg[bkt_reg] <= used_reg[nxt_a];
                    used_reg[nxt_a]   <= 1'b0;
                    if (nxt_a > fp_reg) begin
                        fp_reg <= nxt_a;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign count_out = count_reg;

    always_comb begin
        res_item.status      = status_reg;
        res_item.found       = found_reg;
        res_item.value_out   = vout_reg;
        res_item.entry_count = CNT_W'(count_reg);
    end

endmodule

[sv/chained_scatter_hash_table.sv]
// ----------------------------------------------------------------------------
// chained_scatter_hash_table
// key/value table with coalesced chains, squatter relocation and dense entries
// ----------------------------------------------------------------------------
// One beat is taken at a time; s_ready stays low until the result has been
// moved into the output register, which may still hold an earlier result.
// A request first folds home_bucket into range by repeated subtraction, then
// the search visits the chain from the home bucket link by link. An insert of
// a new key whose home bucket is in use also moves the free pointer past used
// buckets, walks to the chain tail or to the squatter's link, and makes up to
// 3 bucket ram writes. A remove also walks the home chain of the moved last
// entry to relink it, then mends the chain. Every step waits on the registered
// read of the bucket ram or the entry ram, which sets the pace.
`include "assert_macros.svh"

module chained_scatter_hash_table #(
    parameter int BUCKETS = cst_pkg::DEF_BUCKETS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cst_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output cst_pkg::out_t m_payload
);
    import cst_pkg::*;

    localparam int AW = $clog2(BUCKETS);
    localparam int NW = $clog2(BUCKETS + 1);
    localparam int CW = $clog2(BUCKETS + 1);
    localparam int BW = AW + NW;
    localparam int EW = KEY_W + VAL_W + AW;

    logic          res_valid;
    logic          res_ready;
    out_t          res_item;
    logic [CW-1:0] count;
    logic          m_valid_reg;
    out_t          m_payload_reg;

    logic          b_we;
    logic [AW-1:0] b_waddr;
    logic [BW-1:0] b_wdata;
    logic [AW-1:0] b_raddr;
    logic [BW-1:0] b_rdata;
    logic          e_we;
    logic [AW-1:0] e_waddr;
    logic [EW-1:0] e_wdata;
    logic [AW-1:0] e_raddr;
    logic [EW-1:0] e_rdata;

    cst_ctrl #(.BUCKETS(BUCKETS)) u_ctrl (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_payload),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .count_out (count),
        .b_we      (b_we),
        .b_waddr   (b_waddr),
        .b_wdata   (b_wdata),
        .b_raddr   (b_raddr),
        .b_rdata   (b_rdata),
        .e_we      (e_we),
        .e_waddr   (e_waddr),
        .e_wdata   (e_wdata),
        .e_raddr   (e_raddr),
        .e_rdata   (e_rdata)
    );

    // bucket word: entry index and chain link
    cst_ram #(.WIDTH(BW), .DEPTH(BUCKETS)) u_bucket_ram (
        .clk   (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // entry word: key, value and home bucket
    cst_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_entry_ram (
        .clk   (aclk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                m_valid_reg   <= 1'b1;
                m_payload_reg <= res_item;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // checks
    `CST_ASSERT(a_idle_no_result, aclk, aresetn, s_ready |-> !res_valid)
    `CST_ASSERT(a_result_lands, aclk, aresetn, (res_valid && res_ready) |=> m_valid)
    `CST_ASSERT(a_count_bound, aclk, aresetn, count <= CW'(BUCKETS))
    `CST_ASSERT(a_full_not_found, aclk, aresetn, (res_valid && res_item.status == ST_FULL) |-> !res_item.found)

endmodule

[dv/tb_chained_scatter_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_scatter_hash_table
// self-checking bench for the coalesced chained hash table
// ----------------------------------------------------------------------------
// A behavioral copy of the table predicts status, found flag, looked-up value
// and entry count for each accepted request beat. Result beats are compared
// against the oldest prediction. Directed tests cover fill to full, updates,
// key identity across homes, misses, pop on empty and squatter relocation;
// random tests mix operations over small key and home pools.
// ----------------------------------------------------------------------------
module tb_chained_scatter_hash_table;
    import cst_pkg::*;

    localparam int NB = 64;
    localparam int END_MARK = NB;
    localparam longint CYCLE_LIMIT = 10000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;

    chained_scatter_hash_table #(.BUCKETS(NB)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    // table shadow state
    bit          bk_used [NB];
    int          bk_entry [NB];
    int          bk_next [NB];
    logic [31:0] ent_key [NB];
    logic [31:0] ent_val [NB];
    int          ent_home [NB];
    int          n_entries;
    int          spare_ptr;

    out_t expected_results [$];
    int   errors;
    int   results_seen;
    longint cycles;
    bit   quiet_sender;
    bit   quiet_sink;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit chain_find(logic [31:0] k, int h, output int b, output int p);
        int i;
        int pr;
        i = h;
        pr = END_MARK;
        b = 0;
        p = END_MARK;
        for (int s = 0; s < NB; s++) begin
            if (i >= NB || !bk_used[i]) return 0;
            if (bk_entry[i] < n_entries && ent_key[bk_entry[i]] == k &&
                ent_home[bk_entry[i]] == h) begin
                b = i;
                p = pr;
                return 1;
            end
            if (bk_next[i] >= NB) return 0;
            pr = i;
            i = bk_next[i];
        end
        return 0;
    endfunction

    function automatic void claim_bucket(int b, int e);
        bk_used[b] = 1;
        bk_entry[b] = e;
        bk_next[b] = END_MARK;
    endfunction

    // link new entry, relocating a squatter from another chain if needed
    function automatic void link_entry(int e, int h);
        int f;
        int other;
        int p;
        int t;
        if (!bk_used[h]) begin
            claim_bucket(h, e);
            return;
        end
        while (spare_ptr > 0 && spare_ptr < NB && bk_used[spare_ptr]) spare_ptr--;
        f = spare_ptr;
        if (f >= NB || bk_used[f]) return;
        other = ent_home[bk_entry[h] % NB] % NB;
        if (other != h) begin
            p = other;
            for (int s = 0; s < NB && p < NB && bk_next[p] != h; s++) p = bk_next[p];
            if (p >= NB || bk_next[p] != h) return;
            bk_next[p] = f;
            bk_used[f] = 1;
            bk_entry[f] = bk_entry[h];
            bk_next[f] = bk_next[h];
            claim_bucket(h, e);
        end else begin
            t = h;
            for (int s = 0; s < NB && bk_next[t] < NB; s++) t = bk_next[t];
            bk_next[t] = f;
            claim_bucket(f, e);
        end
    endfunction

    // drop bucket b, fill the hole with the last entry, mend the chain
    function automatic void unlink_at(int b, int p);
        int e;
        int lst;
        int i;
        int clr;
        e = bk_entry[b] % NB;
        lst = n_entries - 1;
        if (e != lst && lst < NB) begin
            i = ent_home[lst] % NB;
            for (int s = 0; s < NB; s++) begin
                if (bk_used[i] && bk_entry[i] == lst) begin
                    bk_entry[i] = e;
                    break;
                end
                if (bk_next[i] >= NB) break;
                i = bk_next[i];
            end
            ent_key[e] = ent_key[lst];
            ent_val[e] = ent_val[lst];
            ent_home[e] = ent_home[lst];
        end
        n_entries--;
        if (p < NB) begin
            clr = b;
            bk_next[p] = bk_next[b];
        end else if (bk_next[b] < NB) begin
            clr = bk_next[b];
            bk_used[b] = bk_used[clr];
            bk_entry[b] = bk_entry[clr];
            bk_next[b] = bk_next[clr];
        end else begin
            clr = b;
        end
        bk_used[clr] = 0;
        bk_entry[clr] = 0;
        bk_next[clr] = 0;
        if (clr > spare_ptr) spare_ptr = clr;
    endfunction

    function automatic out_t table_op(in_t req);
        out_t r;
        logic [1:0] fn;
        logic [31:0] k;
        int h;
        int b;
        int p;
        bit remove_it;
        bit pop_empty;
        fn = req.func;
        k = req.key;
        h = int'(req.home_bucket) % NB;
        r = '0;
        r.status = ST_MISS;
        remove_it = 0;
        pop_empty = 0;
        if (fn == FN_POP) begin
            if (n_entries > 0) begin
                k = ent_key[n_entries - 1];
                h = ent_home[n_entries - 1] % NB;
                remove_it = 1;
            end else begin
                pop_empty = 1;
            end
        end
        if (fn == FN_REMOVE) remove_it = 1;
        if (pop_empty) begin
        end else if (fn == FN_LOOKUP) begin
            if (chain_find(k, h, b, p)) begin
                r.status = ST_DONE;
                r.found = 1;
                r.value_out = ent_val[bk_entry[b] % NB];
            end
        end else if (fn == FN_INSERT) begin
            if (chain_find(k, h, b, p)) begin
                ent_val[bk_entry[b] % NB] = req.value;
                r.status = ST_DONE;
                r.found = 1;
            end else if (n_entries >= NB) begin
                r.status = ST_FULL;
            end else begin
                ent_key[n_entries] = k;
                ent_val[n_entries] = req.value;
                ent_home[n_entries] = h;
                n_entries++;
                link_entry(n_entries - 1, h);
                r.status = ST_DONE;
            end
        end else if (remove_it) begin
            if (n_entries > 0 && chain_find(k, h, b, p)) begin
                unlink_at(b, p);
                r.status = ST_DONE;
                r.found = 1;
            end
        end
        r.entry_count = CNT_W'(n_entries);
        return r;
    endfunction

    // result side: random stall and compare against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                out_t want;
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_payload.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_payload.status);
                        errors++;
                    end
                    if (m_payload.found !== want.found) begin
                        $error("found expected %0d actual %0d", want.found, m_payload.found);
                        errors++;
                    end
                    if (m_payload.value_out !== want.value_out) begin
                        $error("value_out expected %h actual %h",
                               want.value_out, m_payload.value_out);
                        errors++;
                    end
                    if (m_payload.entry_count !== want.entry_count) begin
                        $error("entry_count expected %0d actual %0d",
                               want.entry_count, m_payload.entry_count);
                        errors++;
                    end
                end
            end
            m_ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    // valid stays up between back to back beats and drops only while idling
    task automatic send_beat(logic [1:0] fn, logic [31:0] k, logic [5:0] h, logic [31:0] v);
        in_t req;
        req.func = fn;
        req.key = k;
        req.home_bucket = h;
        req.value = v;
        while (!quiet_sender && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(table_op(req));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // fill to full, overflow, update one entry, then empty by pop
    task automatic test_fill_and_full();
        for (int i = 0; i < NB; i++) send_beat(FN_INSERT, 32'hA000 + i, 6'(i * 7), i);
        send_beat(FN_INSERT, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
        send_beat(FN_INSERT, 32'hA000, 6'd0, 32'hFFFF_FFFF);
        send_beat(FN_LOOKUP, 32'hA000, 6'd0, 0);
        for (int i = 0; i < NB + 1; i++) send_beat(FN_POP, $urandom, 6'($urandom), $urandom);
    endtask

    // identity, misses, squatter relocation, extremes
    task automatic test_directed_cases();
        send_beat(FN_LOOKUP, 32'h0, 6'd0, 0);
        send_beat(FN_REMOVE, 32'h0, 6'd0, 0);
        send_beat(FN_INSERT, 32'h0, 6'd0, 32'h0);
        send_beat(FN_INSERT, 32'h0, 6'd63, 32'hFFFF_FFFF);
        send_beat(FN_LOOKUP, 32'h0, 6'd63, 0);
        send_beat(FN_LOOKUP, 32'h0, 6'd0, 0);
        send_beat(FN_INSERT, 32'h1, 6'd5, 32'h11);
        send_beat(FN_INSERT, 32'h2, 6'd5, 32'h22);
        send_beat(FN_INSERT, 32'h3, 6'd5, 32'h33);
        // home 62 now holds a squatter from chain five
        send_beat(FN_INSERT, 32'h4, 6'd62, 32'h44);
        send_beat(FN_LOOKUP, 32'h3, 6'd5, 0);
        send_beat(FN_REMOVE, 32'h1, 6'd5, 0);
        send_beat(FN_LOOKUP, 32'h2, 6'd5, 0);
        send_beat(FN_REMOVE, 32'hFFFF_FFFF, 6'd5, 0);
        send_beat(FN_POP, 0, 0, 0);
        send_beat(FN_LOOKUP, 32'hFFFF_FFFF, 6'd63, 0);
    endtask

    task automatic test_random_mix(int n);
        logic [1:0] fn;
        logic [31:0] k;
        logic [5:0] h;
        int pick;
        for (int i = 0; i < n; i++) begin
            quiet_sender = (i >= n / 3 && i < n / 2);
            quiet_sink = quiet_sender;
            pick = $urandom_range(99);
            fn = pick < 45 ? FN_INSERT : pick < 70 ? FN_LOOKUP : pick < 90 ? FN_REMOVE : FN_POP;
            if ($urandom_range(9) == 0) begin
                k = $urandom;
                h = 6'($urandom);
            end else begin
                k = $urandom_range(40);
                h = 6'($urandom_range(7) * ($urandom_range(3) == 0 ? 9 : 1));
            end
            send_beat(fn, k, h, $urandom);
            if (i == n / 4) wait_drained();
        end
        quiet_sender = 0;
        quiet_sink = 0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        m_ready = 1'b0;
        errors = 0;
        results_seen = 0;
        cycles = 0;
        quiet_sender = 0;
        quiet_sink = 0;
        for (int i = 0; i < NB; i++) begin
            bk_used[i] = 0;
            bk_entry[i] = 0;
            bk_next[i] = 0;
            ent_key[i] = 0;
            ent_val[i] = 0;
            ent_home[i] = 0;
        end
        n_entries = 0;
        spare_ptr = NB - 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_fill_and_full();
        test_random_mix(1600);
        wait_drained();
        $display("covered fill to full, updates, misses, relocation and %0d result beats",
                 results_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
